// ===== rtl/ptts_pkg.sv =====
// ----------------------------------------------------------------------------
// Periodic task tick scheduler package
// Shared operation codes, field widths, controller states and the command and
// status words that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package ptts_pkg;

   localparam int SLOT_COUNT_DEF = 16;
   localparam int MAX_RESULTS    = 16;

   localparam int OP_W       = 3;
   localparam int SLOT_W     = 8;
   localparam int PERIOD_W   = 16;
   localparam int RSP_SLOT_W = 4;

   typedef enum logic [OP_W-1:0] {
      OP_TICK       = 3'd0,
      OP_REGISTER   = 3'd1,
      OP_UNREGISTER = 3'd2,
      OP_PAUSE      = 3'd3,
      OP_RESUME     = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TICK,
      ST_REG,
      ST_SLOT,
      ST_NULL
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic tick_step;
      logic tick_finish;
      logic reg_step;
      logic slot_apply;
      logic null_reply;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_done;
      logic reg_done;
   } sts_type;

endpackage

// ===== rtl/ptts_ctrl.sv =====
// ----------------------------------------------------------------------------
// Periodic task tick scheduler controller
// Dispatches each accepted word to a tick scan, a register search, a single
// slot update or a null reply, and sequences the datapath through it.
// ----------------------------------------------------------------------------
module ptts_ctrl (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [ptts_pkg::OP_W-1:0]          req_operation,
   input  logic [ptts_pkg::PERIOD_W-1:0]      req_period_ticks,
   input  logic                               req_has_handler,
   input  ptts_pkg::sts_type                  sts,
   output ptts_pkg::cmd_type                  cmd,
   output logic                               busy
);

   ptts_pkg::state_type state_ff;
   ptts_pkg::state_type state_in;
   logic                reg_ok;

   // A register request without a handler or with a zero period is refused
   // before any search starts.
   assign reg_ok = req_has_handler && (req_period_ticks != '0);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ptts_pkg::ST_IDLE: begin
            if (start) begin
               unique case (ptts_pkg::op_type'(req_operation)) inside
                  ptts_pkg::OP_TICK:
                     state_in = ptts_pkg::ST_TICK;
                  ptts_pkg::OP_REGISTER:
                     state_in = reg_ok ? ptts_pkg::ST_REG : ptts_pkg::ST_NULL;
                  ptts_pkg::OP_UNREGISTER, ptts_pkg::OP_PAUSE, ptts_pkg::OP_RESUME:
                     state_in = ptts_pkg::ST_SLOT;
                  default:
                     state_in = ptts_pkg::ST_NULL;
               endcase
            end
         end
         ptts_pkg::ST_TICK: begin
            if (sts.scan_done) state_in = ptts_pkg::ST_IDLE;
         end
         ptts_pkg::ST_REG: begin
            if (sts.reg_done) state_in = ptts_pkg::ST_IDLE;
         end
         ptts_pkg::ST_SLOT: state_in = ptts_pkg::ST_IDLE;
         ptts_pkg::ST_NULL: state_in = ptts_pkg::ST_IDLE;
         default:           state_in = ptts_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      unique case (state_ff)
         ptts_pkg::ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ptts_pkg::ST_TICK: begin
            cmd.tick_step   = !sts.scan_done;
            cmd.tick_finish = sts.scan_done;
         end
         ptts_pkg::ST_REG:  cmd.reg_step   = 1'b1;
         ptts_pkg::ST_SLOT: cmd.slot_apply = 1'b1;
         ptts_pkg::ST_NULL: cmd.null_reply = 1'b1;
         default:           cmd            = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptts_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/ptts_dp.sv =====
// ----------------------------------------------------------------------------
// Periodic task tick scheduler datapath
// Holds the slot table, the slot scan counter with its one-stage
// read-modify-write pipe, the pending firing buffer and the result registers.
// ----------------------------------------------------------------------------
module ptts_dp #(
   parameter int SLOT_COUNT = ptts_pkg::SLOT_COUNT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ptts_pkg::cmd_type                   cmd,
   input  logic [ptts_pkg::OP_W-1:0]           req_operation,
   input  logic [ptts_pkg::SLOT_W-1:0]         req_slot_number,
   input  logic [ptts_pkg::PERIOD_W-1:0]       req_period_ticks,
   output ptts_pkg::sts_type                   sts,
   output logic                                rsp_strobe,
   output logic                                rsp_fired,
   output logic [ptts_pkg::RSP_SLOT_W-1:0]     rsp_slot_index,
   output logic                                rsp_accepted,
   output logic                                rsp_last_result
);

   localparam int SIDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int SCAN_W = $clog2(SLOT_COUNT + 1);
   localparam int RPT_W  = $clog2(ptts_pkg::MAX_RESULTS + 1);
   localparam int PW     = ptts_pkg::PERIOD_W;
   localparam int WORD_W = 2 * PW;

   // Table word: period in the upper half, tick counter in the lower half.
   logic [WORD_W-1:0]            mem [SLOT_COUNT];
   logic [WORD_W-1:0]            rd_data_ff;
   logic                         mem_we;
   logic [SIDX_W-1:0]            mem_waddr;
   logic [WORD_W-1:0]            mem_wdata;

   ptts_pkg::op_type             op_ff;
   logic [ptts_pkg::SLOT_W-1:0]  slot_ff;
   logic [PW-1:0]                period_ff;

   logic [SCAN_W-1:0]            scan_ff, scan_in;
   logic                         stage_vld_ff, stage_vld_in;
   logic [SIDX_W-1:0]            stage_idx_ff, stage_idx_in;
   logic                         stage_en_ff, stage_en_in;
   logic                         pend_vld_ff, pend_vld_in;
   logic [SIDX_W-1:0]            pend_idx_ff, pend_idx_in;
   logic [RPT_W-1:0]             reported_ff, reported_in;
   logic [SLOT_COUNT-1:0]        enabled_ff, enabled_in;
   logic [SLOT_COUNT-1:0]        registered_ff, registered_in;

   logic                         emit;
   logic                         emit_fired;
   logic [ptts_pkg::RSP_SLOT_W-1:0] emit_slot;
   logic                         emit_accepted;
   logic                         emit_last;
   logic                         rsp_strobe_ff;
   logic                         rsp_fired_ff;
   logic [ptts_pkg::RSP_SLOT_W-1:0] rsp_slot_index_ff;
   logic                         rsp_accepted_ff;
   logic                         rsp_last_result_ff;

   logic [SIDX_W-1:0]            scan_idx;
   logic                         scan_end;
   logic                         scan_en;
   logic [SIDX_W-1:0]            slot_idx;
   logic                         slot_in_range;
   logic [PW-1:0]                rd_period;
   logic [PW-1:0]                rd_count;
   logic [PW-1:0]                cnt_inc;
   logic                         cnt_hit;

   assign scan_idx      = scan_ff[SIDX_W-1:0];
   assign scan_end      = (scan_ff == SCAN_W'(SLOT_COUNT));
   assign scan_en       = scan_end ? 1'b1 : enabled_ff[scan_idx];
   assign slot_idx      = slot_ff[SIDX_W-1:0];
   assign slot_in_range = (slot_ff < ptts_pkg::SLOT_W'(SLOT_COUNT));
   assign rd_period     = rd_data_ff[WORD_W-1:PW];
   assign rd_count      = rd_data_ff[PW-1:0];
   assign cnt_inc       = rd_count + PW'(1);
   assign cnt_hit       = (cnt_inc >= rd_period);

   assign sts.scan_done = scan_end && !stage_vld_ff;
   assign sts.reg_done  = scan_end || !scan_en;

   always_comb begin
      scan_in       = scan_ff;
      stage_vld_in  = 1'b0;
      stage_idx_in  = stage_idx_ff;
      stage_en_in   = stage_en_ff;
      pend_vld_in   = pend_vld_ff;
      pend_idx_in   = pend_idx_ff;
      reported_in   = reported_ff;
      enabled_in    = enabled_ff;
      registered_in = registered_ff;
      mem_we        = 1'b0;
      mem_waddr     = stage_idx_ff;
      mem_wdata     = {rd_period, cnt_inc};
      emit          = 1'b0;
      emit_fired    = 1'b0;
      emit_slot     = '0;
      emit_accepted = 1'b0;
      emit_last     = 1'b0;

      if (cmd.load) begin
         scan_in     = '0;
         pend_vld_in = 1'b0;
         reported_in = '0;
      end

      if (cmd.tick_step) begin
         if (!scan_end) begin
            stage_vld_in = 1'b1;
            stage_idx_in = scan_idx;
            stage_en_in  = scan_en;
            scan_in      = scan_ff + SCAN_W'(1);
         end
         if (stage_vld_ff && stage_en_ff) begin
            mem_we = 1'b1;
            if (cnt_hit) begin
               mem_wdata = {rd_period, PW'(0)};
               // A firing is held back until the next one is reported so that the final one can
               // carry the last-word mark; firings past the cap go unreported.
               if (reported_ff < RPT_W'(ptts_pkg::MAX_RESULTS)) begin
                  if (pend_vld_ff) begin
                     emit          = 1'b1;
                     emit_fired    = 1'b1;
                     emit_slot     = ptts_pkg::RSP_SLOT_W'(pend_idx_ff);
                     emit_accepted = 1'b1;
                  end
                  pend_vld_in = 1'b1;
                  pend_idx_in = stage_idx_ff;
                  reported_in = reported_ff + RPT_W'(1);
               end
            end
         end
      end

      if (cmd.tick_finish) begin
         emit      = 1'b1;
         emit_last = 1'b1;
         if (pend_vld_ff) begin
            emit_fired    = 1'b1;
            emit_slot     = ptts_pkg::RSP_SLOT_W'(pend_idx_ff);
            emit_accepted = 1'b1;
         end
      end

      if (cmd.reg_step) begin
         if (scan_end) begin
            emit      = 1'b1;
            emit_last = 1'b1;
         end else if (!scan_en) begin
            mem_we                  = 1'b1;
            mem_waddr               = scan_idx;
            mem_wdata               = {period_ff, PW'(0)};
            enabled_in[scan_idx]    = 1'b1;
            registered_in[scan_idx] = 1'b1;
            emit                    = 1'b1;
            emit_slot               = ptts_pkg::RSP_SLOT_W'(scan_idx);
            emit_accepted           = 1'b1;
            emit_last               = 1'b1;
         end else begin
            scan_in = scan_ff + SCAN_W'(1);
         end
      end

      if (cmd.slot_apply) begin
         emit      = 1'b1;
         emit_last = 1'b1;
         if (slot_in_range) begin
            emit_slot = ptts_pkg::RSP_SLOT_W'(slot_ff);
            unique case (op_ff)
               ptts_pkg::OP_UNREGISTER: begin
                  enabled_in[slot_idx]    = 1'b0;
                  registered_in[slot_idx] = 1'b0;
                  emit_accepted           = 1'b1;
               end
               ptts_pkg::OP_PAUSE: begin
                  enabled_in[slot_idx] = 1'b0;
                  emit_accepted        = 1'b1;
               end
               ptts_pkg::OP_RESUME: begin
                  if (registered_ff[slot_idx]) begin
                     enabled_in[slot_idx] = 1'b1;
                     emit_accepted        = 1'b1;
                  end
               end
               default: emit_accepted = 1'b0;
            endcase
         end
      end

      if (cmd.null_reply) begin
         emit      = 1'b1;
         emit_last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[scan_idx];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= ptts_pkg::op_type'(req_operation);
         slot_ff   <= req_slot_number;
         period_ff <= req_period_ticks;
      end
      stage_idx_ff       <= stage_idx_in;
      stage_en_ff        <= stage_en_in;
      pend_idx_ff        <= pend_idx_in;
      rsp_fired_ff       <= emit_fired;
      rsp_slot_index_ff  <= emit_slot;
      rsp_accepted_ff    <= emit_accepted;
      rsp_last_result_ff <= emit_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff       <= '0;
         stage_vld_ff  <= 1'b0;
         pend_vld_ff   <= 1'b0;
         reported_ff   <= '0;
         enabled_ff    <= '0;
         registered_ff <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         scan_ff       <= scan_in;
         stage_vld_ff  <= stage_vld_in;
         pend_vld_ff   <= pend_vld_in;
         reported_ff   <= reported_in;
         enabled_ff    <= enabled_in;
         registered_ff <= registered_in;
         rsp_strobe_ff <= emit;
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_fired       = rsp_fired_ff;
   assign rsp_slot_index  = rsp_slot_index_ff;
   assign rsp_accepted    = rsp_accepted_ff;
   assign rsp_last_result = rsp_last_result_ff;

   // An enabled slot must always be a registered one.
   a_enabled_registered: assert property (@(posedge clock) disable iff (reset)
      (enabled_ff & ~registered_ff) == '0)
      else $error("enabled slot without registration");

   // A held firing has always been counted against the cap.
   a_pending_counted: assert property (@(posedge clock) disable iff (reset)
      pend_vld_ff |-> (reported_ff != '0))
      else $error("pending firing not counted");

   a_report_cap: assert property (@(posedge clock) disable iff (reset)
      reported_ff <= RPT_W'(ptts_pkg::MAX_RESULTS))
      else $error("firing report count above cap");

   // The final tick word is sent only after the pipe has drained.
   a_finish_drained: assert property (@(posedge clock) disable iff (reset)
      cmd.tick_finish |-> (!stage_vld_ff && scan_end))
      else $error("tick finished with slot still in flight");

   a_last_after_finish: assert property (@(posedge clock) disable iff (reset)
      cmd.tick_finish |=> (rsp_strobe_ff && rsp_last_result_ff))
      else $error("tick finish did not produce a last word");

endmodule

// ===== rtl/periodic_task_tick_scheduler_core.sv =====
// A slot operation or refused request gives its word from its ST_SLOT or ST_NULL state,
// and busy falls as that word appears.
// A register search gives its word at the first free slot or table end, one slot per cycle;
// busy falls as that word appears.
// A tick holds busy while it scans and drains, one table read-modify-write per slot per cycle;
// its last word appears as busy falls. Synchronous reset clears slot flags and control.
// ----------------------------------------------------------------------------
// Periodic task tick scheduler core
// Table of periodic task slots with register, unregister, pause, resume and
// tick operations; a tick reports each firing slot, up to MAX_RESULTS, in ascending order.
// ----------------------------------------------------------------------------
module periodic_task_tick_scheduler_core #(
   parameter int SLOT_COUNT = ptts_pkg::SLOT_COUNT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [ptts_pkg::OP_W-1:0]           req_operation,
   input  logic [ptts_pkg::SLOT_W-1:0]         req_slot_number,
   input  logic [ptts_pkg::PERIOD_W-1:0]       req_period_ticks,
   input  logic                                req_has_handler,
   output logic                                rsp_strobe,
   output logic                                rsp_fired,
   output logic [ptts_pkg::RSP_SLOT_W-1:0]     rsp_slot_index,
   output logic                                rsp_accepted,
   output logic                                rsp_last_result
);

   ptts_pkg::cmd_type cmd;
   ptts_pkg::sts_type sts;

   ptts_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .req_operation    (req_operation),
      .req_period_ticks (req_period_ticks),
      .req_has_handler  (req_has_handler),
      .sts              (sts),
      .cmd              (cmd),
      .busy             (busy)
   );

   ptts_dp #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_operation    (req_operation),
      .req_slot_number  (req_slot_number),
      .req_period_ticks (req_period_ticks),
      .sts              (sts),
      .rsp_strobe       (rsp_strobe),
      .rsp_fired        (rsp_fired),
      .rsp_slot_index   (rsp_slot_index),
      .rsp_accepted     (rsp_accepted),
      .rsp_last_result  (rsp_last_result)
   );

endmodule

// ===== verif/tb_periodic_task_tick_scheduler_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the periodic task tick scheduler core
// Drives a directed table and then random command words. A copy of the slot
// table in the testbench works out the result words of each accepted command
// without a typed word; every result word is checked field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_periodic_task_tick_scheduler_core;

   localparam int SLOTS       = ptts_pkg::SLOT_COUNT_DEF;
   localparam int OPW         = ptts_pkg::OP_W;
   localparam int SW          = ptts_pkg::SLOT_W;
   localparam int PW          = ptts_pkg::PERIOD_W;
   localparam int RSW         = ptts_pkg::RSP_SLOT_W;
   localparam int CYCLE_LIMIT = 20000;

   // Operation codes that the block does not know and answers with a null reply.
   localparam logic [OPW-1:0] OP_SPARE_LO = 3'd5;
   localparam logic [OPW-1:0] OP_SPARE_MID = 3'd6;
   localparam logic [OPW-1:0] OP_SPARE_HI = 3'd7;

   typedef struct packed {
      logic           fired;
      logic [RSW-1:0] slot_index;
      logic           accepted;
      logic           last_result;
   } rsp_word_type;

   typedef struct {
      logic [OPW-1:0] op;
      logic [SW-1:0]  slot;
      logic [PW-1:0]  period;
      logic           handler;
      bit             typed;
      rsp_word_type   word;
   } cmd_row_type;

   logic           clock = 1'b0;
   logic           reset = 1'b1;
   logic           start = 1'b0;
   logic           busy;
   logic [OPW-1:0] req_operation = '0;
   logic [SW-1:0]  req_slot_number = '0;
   logic [PW-1:0]  req_period_ticks = '0;
   logic           req_has_handler = 1'b0;
   logic           rsp_strobe;
   logic           rsp_fired;
   logic [RSW-1:0] rsp_slot_index;
   logic           rsp_accepted;
   logic           rsp_last_result;

   // Shadow copy of the slot table.
   logic [PW-1:0] period_tbl [SLOTS];
   logic [PW-1:0] count_tbl [SLOTS];
   bit            enabled_tbl [SLOTS];
   bit            registered_tbl [SLOTS];

   rsp_word_type expected_words[$];
   rsp_word_type table_words[$];
   cmd_row_type  pending_cmds[$];
   cmd_row_type  directed_rows[$];

   int  items_taken = 0;
   int  words_checked = 0;
   int  firings_seen = 0;
   int  error_count = 0;
   int  cycle_count = 0;
   bit  idle_enable = 1'b1;

   periodic_task_tick_scheduler_core #(.SLOT_COUNT(SLOTS)) u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_slot_number  (req_slot_number),
      .req_period_ticks (req_period_ticks),
      .req_has_handler  (req_has_handler),
      .rsp_strobe       (rsp_strobe),
      .rsp_fired        (rsp_fired),
      .rsp_slot_index   (rsp_slot_index),
      .rsp_accepted     (rsp_accepted),
      .rsp_last_result  (rsp_last_result)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic void clear_table();
      for (int i = 0; i < SLOTS; i++) begin
         period_tbl[i] = '0;
         count_tbl[i] = '0;
         enabled_tbl[i] = 1'b0;
         registered_tbl[i] = 1'b0;
      end
   endfunction

   // Applies one command to the shadow table and leaves its words in table_words.
   function automatic void run_table_cmd(input logic [OPW-1:0] op,
                                         input logic [SW-1:0] slot,
                                         input logic [PW-1:0] period,
                                         input logic handler);
      int           fire_count;
      bit           granted;
      rsp_word_type word;
      table_words.delete();
      word = '{1'b0, '0, 1'b0, 1'b1};
      case (op)
         ptts_pkg::OP_TICK: begin
            fire_count = 0;
            for (int i = 0; i < SLOTS; i++) begin
               if (enabled_tbl[i]) begin
                  count_tbl[i] = count_tbl[i] + PW'(1);
                  if (count_tbl[i] >= period_tbl[i]) begin
                     count_tbl[i] = '0;
                     if (fire_count < ptts_pkg::MAX_RESULTS) begin
                        table_words.push_back('{1'b1, RSW'(i), 1'b1, 1'b0});
                        fire_count++;
                     end
                  end
               end
            end
            if (fire_count == 0)
               table_words.push_back(word);
            else
               table_words[fire_count-1].last_result = 1'b1;
         end
         ptts_pkg::OP_REGISTER: begin
            granted = 1'b0;
            if (handler && period != '0) begin
               for (int i = 0; i < SLOTS && !granted; i++) begin
                  if (!enabled_tbl[i]) begin
                     period_tbl[i] = period;
                     count_tbl[i] = '0;
                     enabled_tbl[i] = 1'b1;
                     registered_tbl[i] = 1'b1;
                     word.slot_index = RSW'(i);
                     word.accepted = 1'b1;
                     granted = 1'b1;
                  end
               end
            end
            table_words.push_back(word);
         end
         ptts_pkg::OP_UNREGISTER, ptts_pkg::OP_PAUSE, ptts_pkg::OP_RESUME: begin
            if (slot < SLOTS) begin
               word.slot_index = slot[RSW-1:0];
               word.accepted = 1'b1;
               if (op == ptts_pkg::OP_UNREGISTER) begin
                  enabled_tbl[slot] = 1'b0;
                  registered_tbl[slot] = 1'b0;
                  count_tbl[slot] = '0;
                  period_tbl[slot] = '0;
               end else if (op == ptts_pkg::OP_PAUSE) begin
                  enabled_tbl[slot] = 1'b0;
               end else if (registered_tbl[slot]) begin
                  enabled_tbl[slot] = 1'b1;
               end else begin
                  word.accepted = 1'b0;
               end
            end
            table_words.push_back(word);
         end
         default: table_words.push_back(word);
      endcase
   endfunction

   task automatic check_field(input string name, input logic [3:0] want,
                              input logic [3:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   // Result words are checked first, then a command taken at the same edge is
   // predicted, so its words always queue behind those of earlier commands.
   always @(posedge clock) begin : result_monitor
      rsp_word_type want;
      cmd_row_type  cmd;
      if (!reset) begin
         if (rsp_strobe) begin
            words_checked++;
            if (rsp_fired === 1'b1)
               firings_seen++;
            if (expected_words.size() == 0) begin
               $display("%0t: result word with none expected (fired %0b slot %0d)",
                        $time, rsp_fired, rsp_slot_index);
               error_count++;
            end else begin
               want = expected_words.pop_front();
               check_field("fired", want.fired, rsp_fired);
               check_field("slot_index", want.slot_index, rsp_slot_index);
               check_field("accepted", want.accepted, rsp_accepted);
               check_field("last_result", want.last_result, rsp_last_result);
            end
         end
         if (start && !busy) begin
            cmd = pending_cmds.pop_front();
            run_table_cmd(req_operation, req_slot_number, req_period_ticks,
                          req_has_handler);
            if (cmd.typed)
               expected_words.push_back(cmd.word);
            else
               foreach (table_words[i]) expected_words.push_back(table_words[i]);
            items_taken++;
         end
      end
   end

   task automatic add_row(input logic [OPW-1:0] op, input logic [SW-1:0] slot,
                          input logic [PW-1:0] period, input logic handler,
                          input bit typed, input logic [RSW-1:0] idx = '0,
                          input logic acc = 1'b0);
      cmd_row_type row;
      row = '{op, slot, period, handler, typed, '{1'b0, idx, acc, 1'b1}};
      directed_rows.push_back(row);
   endtask

   function automatic cmd_row_type random_row();
      cmd_row_type row;
      int          pick;
      row.typed = 1'b0;
      row.word = '0;
      row.slot = ($urandom_range(99) < 85) ? SW'($urandom_range(SLOTS-1))
                                            : SW'($urandom_range(255));
      pick = $urandom_range(99);
      if (pick < 80)
         row.period = PW'($urandom_range(1, 5));
      else if (pick < 93)
         row.period = PW'($urandom_range(16'hFFFF));
      else
         row.period = '0;
      row.handler = ($urandom_range(19) != 0);
      pick = $urandom_range(99);
      if (pick < 30)
         row.op = ptts_pkg::OP_REGISTER;
      else if (pick < 62)
         row.op = ptts_pkg::OP_TICK;
      else if (pick < 72)
         row.op = ptts_pkg::OP_PAUSE;
      else if (pick < 84)
         row.op = ptts_pkg::OP_RESUME;
      else if (pick < 96)
         row.op = ptts_pkg::OP_UNREGISTER;
      else
         row.op = OPW'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
      return row;
   endfunction

   // Called at a falling edge; returns at the falling edge after the word is taken.
   task automatic send_word(input cmd_row_type row);
      int taken_before;
      if (idle_enable && $urandom_range(99) < 34) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_operation <= row.op;
      req_slot_number <= row.slot;
      req_period_ticks <= row.period;
      req_has_handler <= row.handler;
      start <= 1'b1;
      pending_cmds.push_back(row);
      taken_before = items_taken;
      do @(negedge clock); while (items_taken == taken_before);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      @(negedge clock);
      while (expected_words.size() != 0) @(negedge clock);
   endtask

   initial begin : stimulus
      cmd_row_type row;
      clear_table();

      add_row(ptts_pkg::OP_TICK, 8'd0, 16'd0, 1'b0, 1'b1);
      add_row(ptts_pkg::OP_REGISTER, 8'd0, 16'd0, 1'b1, 1'b1);
      add_row(ptts_pkg::OP_REGISTER, 8'd0, 16'd5, 1'b0, 1'b1);
      add_row(ptts_pkg::OP_REGISTER, 8'd0, 16'd1, 1'b1, 1'b1, 4'd0, 1'b1);
      add_row(ptts_pkg::OP_REGISTER, 8'hFF, 16'hFFFF, 1'b1, 1'b1, 4'd1, 1'b1);
      add_row(ptts_pkg::OP_REGISTER, 8'd7, 16'd2, 1'b1, 1'b1, 4'd2, 1'b1);
      add_row(ptts_pkg::OP_TICK, 8'd0, 16'd0, 1'b0, 1'b0);
      add_row(ptts_pkg::OP_TICK, 8'hA5, 16'h5A5A, 1'b1, 1'b0);
      add_row(ptts_pkg::OP_PAUSE, 8'd0, 16'd0, 1'b0, 1'b1, 4'd0, 1'b1);
      add_row(ptts_pkg::OP_TICK, 8'd0, 16'd0, 1'b0, 1'b0);
      add_row(ptts_pkg::OP_RESUME, 8'hFF, 16'd0, 1'b0, 1'b1);
      add_row(ptts_pkg::OP_UNREGISTER, 8'd16, 16'd0, 1'b0, 1'b1);
      add_row(ptts_pkg::OP_PAUSE, 8'h80, 16'd0, 1'b0, 1'b1);
      add_row(ptts_pkg::OP_RESUME, 8'd15, 16'd0, 1'b0, 1'b1, 4'd15, 1'b0);
      add_row(ptts_pkg::OP_RESUME, 8'd0, 16'd0, 1'b0, 1'b1, 4'd0, 1'b1);
      add_row(ptts_pkg::OP_PAUSE, 8'd0, 16'd0, 1'b0, 1'b1, 4'd0, 1'b1);
      // A paused slot is the lowest one not enabled, so register takes it back.
      add_row(ptts_pkg::OP_REGISTER, 8'd9, 16'd3, 1'b1, 1'b1, 4'd0, 1'b1);
      add_row(ptts_pkg::OP_UNREGISTER, 8'd1, 16'd0, 1'b0, 1'b1, 4'd1, 1'b1);
      add_row(ptts_pkg::OP_RESUME, 8'd1, 16'd0, 1'b0, 1'b1, 4'd1, 1'b0);
      add_row(OP_SPARE_LO, 8'h5A, 16'hFFFF, 1'b1, 1'b1);
      add_row(OP_SPARE_MID, 8'd3, 16'd1, 1'b1, 1'b1);
      add_row(OP_SPARE_HI, 8'd2, 16'd2, 1'b0, 1'b1);
      add_row(ptts_pkg::OP_TICK, 8'd0, 16'd0, 1'b0, 1'b0);
      add_row(ptts_pkg::OP_TICK, 8'd0, 16'd0, 1'b0, 1'b0);

      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) send_word(directed_rows[i]);
      drain_results();

      repeat (25) send_word(random_row());
      drain_results();

      // Back-to-back stretch: fill every slot, overflow the table, then tick it.
      idle_enable = 1'b0;
      repeat (SLOTS + 2) begin
         row = random_row();
         row.op = ptts_pkg::OP_REGISTER;
         row.period = PW'($urandom_range(1, 3));
         row.handler = 1'b1;
         send_word(row);
      end
      repeat (8) begin
         row = random_row();
         row.op = ptts_pkg::OP_TICK;
         send_word(row);
      end
      idle_enable = 1'b1;

      repeat (25) send_word(random_row());

      drain_results();
      repeat (2 * SLOTS + 8) @(negedge clock);

      $display("Ran %0d command words and checked %0d result words, %0d of them firings.",
               items_taken, words_checked, firings_seen);
      $display("Covered rejected and reused registers, a full table, and ignored commands.");
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/ptts_pkg.sv
rtl/ptts_ctrl.sv
rtl/ptts_dp.sv
rtl/periodic_task_tick_scheduler_core.sv
verif/tb_periodic_task_tick_scheduler_core.sv
